FILE: hw/rtl/lisa_pkg.sv
package lisa_pkg;

   localparam int SLOT_COUNT  = 32;
   localparam int SLOT_BYTES  = 256;
   localparam int INDEX_DEPTH = 32;
   localparam int HDR_BYTES   = 8;
   localparam int IDX_W       = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
   localparam int CNT_W       = $clog2(INDEX_DEPTH + 1);

   // Request codes.
   localparam logic [1:0] REQ_APPEND  = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_COMPACT = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_TOO_BIG   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // One index entry as stored in memory: key, seq, slot, len.
   localparam int ENTRY_W = 32 + 32 + 5 + 9;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] seq;
      logic [4:0]  slot;
      logic [8:0]  len;
   } entry_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] key;
      logic [15:0] payload_len;
      logic [15:0] read_cap;
   } req_type_s_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  slot_no;
      logic [31:0] seq_no;
      logic [8:0]  entry_len;
      logic [5:0]  match_count;
      logic [13:0] total_bytes;
      logic [5:0]  entries_left;
      logic        last;
   } rsp_type;

endpackage

FILE: hw/rtl/log_index_slot_allocator_unit.sv
// Index and slot allocator of an append-only key log. A request beat is taken
// at a rising edge where start is high and busy is low, and busy stays high
// until the request is finished. Each result beat is shown for one cycle with
// rsp_valid high and cannot be held off, so the receiver must take every beat
// as it comes. An append gives its single result beat while in S_DONE, and busy
// falls at the end of that cycle. A read checks the index entries in turn, each
// with a memory read in S_RD_WAIT and then the compare in S_RD_CHK, and holds
// each match back until the next match or the end of the scan so that it can
// mark the final beat. A compact compares each entry's key against the later
// keys, one memory read per cycle, then copies the kept entries down, each with
// a read in S_P_RD and then a write in S_P_WR. Payload bytes are not handled;
// only slot numbers are.
module log_index_slot_allocator_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  lisa_pkg::req_type_s_type req_data,
   output logic                     rsp_valid,
   output lisa_pkg::rsp_type        rsp_data
);

   localparam int IW = lisa_pkg::IDX_W;
   localparam int CW = lisa_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_APPEND, S_RD_WAIT, S_RD_CHK, S_C_I, S_C_IWAIT, S_C_J, S_C_JCHK,
      S_P_RD, S_P_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   lisa_pkg::req_type_s_type req_ff, req_in;
   logic [lisa_pkg::SLOT_COUNT-1:0] used_ff, used_in;
   logic [CW-1:0] total_ff, total_in;
   logic [31:0] nseq_ff, nseq_in;
   logic [lisa_pkg::INDEX_DEPTH-1:0] drop_ff, drop_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, w_ff, w_in;
   logic [31:0] keyi_ff, keyi_in;
   logic [4:0] sloti_ff, sloti_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [16:0] tot_ff, tot_in;
   lisa_pkg::rsp_type pend_ff, pend_in;
   logic pend_v_ff, pend_v_in;
   lisa_pkg::rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   // Index memory port signals.
   logic wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   lisa_pkg::entry_type wr_data, rd_data;

   lisa_ram #(.WIDTH(lisa_pkg::ENTRY_W), .DEPTH(lisa_pkg::INDEX_DEPTH)) u_index (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Lowest free slot from the bitmap.
   logic [4:0] free_slot;
   logic free_found;
   always_comb begin
      free_slot = '0;
      free_found = 1'b0;
      for (int s = lisa_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
         if (!used_ff[s]) begin
            free_slot = 5'(s);
            free_found = 1'b1;
         end
      end
   end

   logic [16:0] need;
   logic [16:0] sum;
   logic key_hit;
   logic fits;
   assign need = {1'b0, req_ff.payload_len} + 17'(lisa_pkg::HDR_BYTES);
   assign sum = tot_ff + 17'(rd_data.len);
   assign key_hit = (rd_data.key == req_ff.key);
   assign fits = (sum <= {1'b0, req_ff.read_cap});

   // Final beat of a read: the held match marked last, or not found.
   lisa_pkg::rsp_type final_rsp;
   always_comb begin
      if (pend_v_ff) begin
         final_rsp = pend_ff;
      end else begin
         final_rsp = '0;
         final_rsp.status = lisa_pkg::ST_NOT_FOUND;
         final_rsp.entries_left = 6'(total_ff);
      end
      final_rsp.last = 1'b1;
   end

   // Memory address and write control.
   always_comb begin
      rd_addr = i_ff[IW-1:0];
      wr_en = 1'b0;
      wr_addr = total_ff[IW-1:0];
      wr_data.key = req_ff.key;
      wr_data.seq = nseq_ff;
      wr_data.slot = free_slot;
      wr_data.len = need[8:0];
      unique case (state_ff)
         S_C_J: rd_addr = j_ff[IW-1:0];
         S_C_JCHK: rd_addr = IW'(j_ff + 1'b1);
         S_APPEND: wr_en = (need <= 17'(lisa_pkg::SLOT_BYTES))
            && (total_ff < CW'(lisa_pkg::INDEX_DEPTH)) && free_found;
         S_P_WR: begin
            wr_en = !drop_ff[i_ff[IW-1:0]];
            wr_addr = w_ff[IW-1:0];
            wr_data = rd_data;
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   // Next state, bookkeeping and result beat.
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      used_in = used_ff;
      total_in = total_ff;
      nseq_in = nseq_ff;
      drop_in = drop_ff;
      i_in = i_ff;
      j_in = j_ff;
      w_in = w_ff;
      keyi_in = keyi_ff;
      sloti_in = sloti_ff;
      cnt_in = cnt_ff;
      tot_in = tot_ff;
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      rv_in = 1'b0;
      rsp_in = '0;
      rsp_in.entries_left = 6'(total_ff);
      rsp_in.last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            i_in = '0;
            j_in = '0;
            w_in = '0;
            cnt_in = '0;
            tot_in = '0;
            pend_v_in = 1'b0;
            drop_in = '0;
            if (start) begin
               req_in = req_data;
               unique case (req_data.req_type)
                  lisa_pkg::REQ_APPEND: state_in = S_APPEND;
                  lisa_pkg::REQ_READ: state_in = S_RD_WAIT;
                  lisa_pkg::REQ_COMPACT: state_in = S_C_I;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_APPEND: begin
            rv_in = 1'b1;
            state_in = S_DONE;
            if (need > 17'(lisa_pkg::SLOT_BYTES)) begin
               rsp_in.status = lisa_pkg::ST_TOO_BIG;
            end else if (wr_en) begin
               used_in[free_slot] = 1'b1;
               total_in = total_ff + 1'b1;
               nseq_in = nseq_ff + 32'd1;
               rsp_in.status = lisa_pkg::ST_OK;
               rsp_in.slot_no = free_slot;
               rsp_in.seq_no = nseq_ff;
               rsp_in.entry_len = need[8:0];
               rsp_in.entries_left = 6'(total_ff + 1'b1);
            end else begin
               rsp_in.status = lisa_pkg::ST_FULL;
            end
         end
         S_RD_WAIT: begin
            // End of scan sends the held match as the last beat, or not found if none is held.
            if (i_ff >= total_ff) begin
               rv_in = 1'b1;
               rsp_in = final_rsp;
               state_in = S_DONE;
            end else begin
               state_in = S_RD_CHK;
            end
         end
         S_RD_CHK: begin
            // Data for entry i is on rd_data now.
            if (key_hit && !fits) begin
               rv_in = 1'b1;
               rsp_in = final_rsp;
               state_in = S_DONE;
            end else begin
               if (key_hit) begin
                  // A new match releases the held one, which is not last.
                  rv_in = pend_v_ff;
                  rsp_in = pend_ff;
                  pend_v_in = 1'b1;
                  pend_in.status = lisa_pkg::ST_OK;
                  pend_in.slot_no = rd_data.slot;
                  pend_in.seq_no = rd_data.seq;
                  pend_in.entry_len = rd_data.len;
                  pend_in.match_count = cnt_ff + 6'd1;
                  pend_in.total_bytes = sum[13:0];
                  pend_in.entries_left = 6'(total_ff);
                  pend_in.last = 1'b0;
                  cnt_in = cnt_ff + 6'd1;
                  tot_in = sum;
               end
               i_in = i_ff + 1'b1;
               state_in = S_RD_WAIT;
            end
         end
         S_C_I: begin
            // Outer loop: fetch key of entry i.
            if (i_ff >= total_ff) begin
               i_in = '0;
               state_in = S_P_RD;
            end else begin
               j_in = i_ff + 1'b1;
               state_in = S_C_IWAIT;
            end
         end
         S_C_IWAIT: begin
            state_in = S_C_J;
         end
         S_C_J: begin
            keyi_in = rd_data.key;
            sloti_in = rd_data.slot;
            if (j_ff >= total_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_C_I;
            end else begin
               state_in = S_C_JCHK;
            end
         end
         S_C_JCHK: begin
            // Entry j is on rd_data; entry j + 1 is being read.
            if (rd_data.key == keyi_ff) begin
               drop_in[i_ff[IW-1:0]] = 1'b1;
               used_in[sloti_ff] = 1'b0;
               i_in = i_ff + 1'b1;
               state_in = S_C_I;
            end else if (j_ff + 1'b1 >= total_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_C_I;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_P_RD: begin
            if (i_ff >= total_ff) begin
               total_in = w_ff;
               rv_in = 1'b1;
               rsp_in.entries_left = 6'(w_ff);
               state_in = S_DONE;
            end else begin
               state_in = S_P_WR;
            end
         end
         S_P_WR: begin
            if (wr_en) begin
               w_in = w_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
            state_in = S_P_RD;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer; holds state and registered result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         req_ff <= '0;
         used_ff <= '0;
         total_ff <= '0;
         nseq_ff <= 32'd1;
         drop_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         w_ff <= '0;
         keyi_ff <= '0;
         sloti_ff <= '0;
         cnt_ff <= '0;
         tot_ff <= '0;
         pend_ff <= '0;
         pend_v_ff <= 1'b0;
         rsp_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         req_ff <= req_in;
         used_ff <= used_in;
         total_ff <= total_in;
         nseq_ff <= nseq_in;
         drop_ff <= drop_in;
         i_ff <= i_in;
         j_ff <= j_in;
         w_ff <= w_in;
         keyi_ff <= keyi_in;
         sloti_ff <= sloti_in;
         cnt_ff <= cnt_in;
         tot_ff <= tot_in;
         pend_ff <= pend_in;
         pend_v_ff <= pend_v_in;
         rsp_ff <= rsp_in;
         rv_ff <= rv_in;
      end
   end

endmodule

FILE: hw/rtl/lisa_ram.sv
// Single-port write, single-port read RAM with registered read data.
module lisa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sim/tb_log_index_slot_allocator_unit.sv
module tb_log_index_slot_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Request code that the block ignores.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   lisa_pkg::req_type_s_type req_data;
   logic                     rsp_valid;
   lisa_pkg::rsp_type        rsp_data;

   log_index_slot_allocator_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // Shadow copy of the index and the slot bitmap.
   logic [31:0] shadow_used;
   logic [31:0] shadow_key [32];
   logic [31:0] shadow_seq [32];
   logic [4:0]  shadow_slot [32];
   logic [8:0]  shadow_len [32];
   int          shadow_total;
   logic [31:0] shadow_next_seq;

   lisa_pkg::req_type_s_type pending_reqs[$];
   lisa_pkg::rsp_type        expected_rsps[$];
   int             error_count = 0;
   int             gap_left = 0;
   bit             hold_for_drain = 0;
   bit             busy_seen;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic lisa_pkg::rsp_type make_rsp(logic [1:0] st, logic [4:0] sl,
                                                  logic [31:0] sq, logic [8:0] ln,
                                                  int cnt, int tot, int left, logic lst);
      lisa_pkg::rsp_type r;
      r.status = st; r.slot_no = sl; r.seq_no = sq; r.entry_len = ln;
      r.match_count = cnt[5:0]; r.total_bytes = tot[13:0];
      r.entries_left = left[5:0]; r.last = lst;
      return r;
   endfunction

   function automatic lisa_pkg::req_type_s_type make_req(logic [1:0] rt, logic [31:0] k,
                                                         logic [15:0] vl, logic [15:0] cap);
      lisa_pkg::req_type_s_type r;
      r.req_type = rt; r.key = k; r.payload_len = vl; r.read_cap = cap;
      return r;
   endfunction

   // Predict the results of one accepted request beat and update the shadow.
   task automatic predict_request(input lisa_pkg::req_type_s_type rq);
      int need, fslot, total, count, w;
      bit drop [32];
      need = int'(rq.payload_len) + lisa_pkg::HDR_BYTES;
      if (rq.req_type == lisa_pkg::REQ_APPEND) begin
         fslot = -1;
         for (int i = lisa_pkg::SLOT_COUNT - 1; i >= 0; i--)
            if (!shadow_used[i]) fslot = i;
         if (need > lisa_pkg::SLOT_BYTES) begin
            expected_rsps.push_back(make_rsp(lisa_pkg::ST_TOO_BIG, 5'd0, 32'd0, 9'd0,
                                             0, 0, shadow_total, 1'b1));
         end else if (shadow_total >= lisa_pkg::INDEX_DEPTH || fslot < 0) begin
            expected_rsps.push_back(make_rsp(lisa_pkg::ST_FULL, 5'd0, 32'd0, 9'd0,
                                             0, 0, shadow_total, 1'b1));
         end else begin
            shadow_used[fslot] = 1'b1;
            shadow_key[shadow_total] = rq.key;
            shadow_seq[shadow_total] = shadow_next_seq;
            shadow_slot[shadow_total] = fslot[4:0];
            shadow_len[shadow_total] = need[8:0];
            shadow_total++;
            expected_rsps.push_back(make_rsp(lisa_pkg::ST_OK, fslot[4:0], shadow_next_seq,
                                             need[8:0], 0, 0, shadow_total, 1'b1));
            shadow_next_seq = shadow_next_seq + 32'd1;
         end
      end else if (rq.req_type == lisa_pkg::REQ_READ) begin
         total = 0;
         count = 0;
         for (int i = 0; i < shadow_total; i++) begin
            if (shadow_key[i] != rq.key) continue;
            if (total + int'(shadow_len[i]) > int'(rq.read_cap)) break;
            total += shadow_len[i];
            count++;
            expected_rsps.push_back(make_rsp(lisa_pkg::ST_OK, shadow_slot[i], shadow_seq[i],
                                             shadow_len[i], count, total, shadow_total,
                                             1'b0));
         end
         if (count == 0)
            expected_rsps.push_back(make_rsp(lisa_pkg::ST_NOT_FOUND, 5'd0, 32'd0, 9'd0,
                                             0, 0, shadow_total, 1'b1));
         else
            expected_rsps[$].last = 1'b1;
      end else if (rq.req_type == lisa_pkg::REQ_COMPACT) begin
         for (int i = 0; i < 32; i++) drop[i] = 0;
         for (int i = 0; i < shadow_total; i++)
            for (int j = i + 1; j < shadow_total; j++)
               if (shadow_key[j] == shadow_key[i]) begin
                  drop[i] = 1;
                  shadow_used[shadow_slot[i]] = 1'b0;
                  break;
               end
         w = 0;
         for (int i = 0; i < shadow_total; i++)
            if (!drop[i]) begin
               shadow_key[w] = shadow_key[i]; shadow_seq[w] = shadow_seq[i];
               shadow_slot[w] = shadow_slot[i]; shadow_len[w] = shadow_len[i];
               w++;
            end
         shadow_total = w;
         expected_rsps.push_back(make_rsp(lisa_pkg::ST_OK, 5'd0, 32'd0, 9'd0,
                                          0, 0, shadow_total, 1'b1));
      end
   endtask

   // Driver: launch one beat at the falling edge after a random gap.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else if (start && !busy_seen) begin
         // Beat still waiting for acceptance; hold it.
      end else if (hold_for_drain && expected_rsps.size() != 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (pending_reqs.size() != 0) begin
         req_data <= pending_reqs.pop_front();
         start <= 1'b1;
         gap_left = $urandom_range(0, 7);
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: compare each result beat against the oldest expectation, then
   // note whether the current request beat was taken at this edge.
   always @(posedge clock) begin
      lisa_pkg::rsp_type exp_rsp;
      if (reset) begin
         busy_seen <= 1'b1;
         shadow_used = '0;
         shadow_total = 0;
         shadow_next_seq = 32'd1;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result beat");
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data.status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0d exp %0d", rsp_data.status,
                                            exp_rsp.status));
               if (rsp_data.slot_no !== exp_rsp.slot_no)
                  report_mismatch($sformatf("slot %0d exp %0d", rsp_data.slot_no,
                                            exp_rsp.slot_no));
               if (rsp_data.seq_no !== exp_rsp.seq_no)
                  report_mismatch($sformatf("seq %0d exp %0d", rsp_data.seq_no,
                                            exp_rsp.seq_no));
               if (rsp_data.entry_len !== exp_rsp.entry_len)
                  report_mismatch($sformatf("len %0d exp %0d", rsp_data.entry_len,
                                            exp_rsp.entry_len));
               if (rsp_data.match_count !== exp_rsp.match_count)
                  report_mismatch($sformatf("count %0d exp %0d", rsp_data.match_count,
                                            exp_rsp.match_count));
               if (rsp_data.total_bytes !== exp_rsp.total_bytes)
                  report_mismatch($sformatf("total %0d exp %0d", rsp_data.total_bytes,
                                            exp_rsp.total_bytes));
               if (rsp_data.entries_left !== exp_rsp.entries_left)
                  report_mismatch($sformatf("left %0d exp %0d", rsp_data.entries_left,
                                            exp_rsp.entries_left));
               if (rsp_data.last !== exp_rsp.last)
                  report_mismatch($sformatf("last %0d exp %0d", rsp_data.last,
                                            exp_rsp.last));
            end
         end
         if (start && !busy) begin
            predict_request(req_data);
            busy_seen <= 1'b1;
         end else if (start) begin
            busy_seen <= 1'b0;
         end else begin
            busy_seen <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [31:0] key_pool [4];
      int          pick;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: size limits, reads, compact, unknown type, full index.
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'h0, 16'h0, 16'hFFFF));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'hFFFFFFFF, 16'd248, 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'h1, 16'd249, 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'h1, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'hFFFFFFFF, 16'd0, 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'h0, 16'd5, 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'hFFFFFFFF, 16'h0, 16'hFFFF));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'hFFFFFFFF, 16'h0, 16'd256));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'hFFFFFFFF, 16'h0, 16'd255));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'h12345678, 16'h0, 16'hFFFF));
      pending_reqs.push_back(make_req(REQ_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_COMPACT, 32'h0, 16'h0, 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'hFFFFFFFF, 16'h0, 16'hFFFF));
      for (int i = 0; i < 32; i++)
         pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'(i % 3), 16'(i), 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND, 32'h7, 16'd1, 16'h0));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_READ, 32'h0, 16'h0, 16'hFFFF));
      pending_reqs.push_back(make_req(lisa_pkg::REQ_COMPACT, 32'h0, 16'h0, 16'h0));
      wait (pending_reqs.size() == 0);

      // Drain pause: hold the sender until every result has come.
      hold_for_drain = 1;
      wait (expected_rsps.size() == 0 && !start);
      hold_for_drain = 0;

      // Random: mostly appends and reads over a small key pool.
      for (int i = 0; i < 4; i++) key_pool[i] = $urandom;
      for (int n = 0; n < 52; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            pending_reqs.push_back(make_req(lisa_pkg::REQ_APPEND,
                                            key_pool[$urandom_range(0, 3)],
                                            ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                            16'($urandom_range(0, 250)), 16'($urandom)));
         else if (pick < 82)
            pending_reqs.push_back(make_req(lisa_pkg::REQ_READ,
                                            ($urandom_range(0, 7) == 0) ? $urandom :
                                            key_pool[$urandom_range(0, 3)], 16'($urandom),
                                            ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                            16'($urandom_range(0, 1200))));
         else if (pick < 95)
            pending_reqs.push_back(make_req(lisa_pkg::REQ_COMPACT, $urandom, 16'($urandom),
                                            16'($urandom)));
         else
            pending_reqs.push_back(make_req(REQ_UNUSED, $urandom, 16'($urandom),
                                            16'($urandom)));
         if (n % 25 == 24) key_pool[$urandom_range(0, 3)] = $urandom;
      end
      wait (pending_reqs.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (1200) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
